@@ hw/rtl/sdr_pkg.sv @@
// Package for the signed divide/remainder block.
// Holds the data width, the channel payload types and the pipeline stage type.
// No dependencies.
package sdr_pkg;

   localparam int DATA_WIDTH = 32;

   localparam logic MODE_QUOTIENT  = 1'b0;
   localparam logic MODE_REMAINDER = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic signed [DATA_WIDTH-1:0] dividend;
      logic signed [DATA_WIDTH-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic                         divide_by_zero;
   } rsp_type;

   // One item in flight through the divider array. acc starts as the dividend
   // magnitude and fills with quotient bits from the bottom as it shifts out.
   typedef struct packed {
      logic                  mode;
      logic                  neg_a;
      logic                  neg_b;
      logic                  dz;
      logic [DATA_WIDTH-1:0] ub;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] acc;
   } stage_type;

endpackage

@@ hw/rtl/signed_divide_remainder.sv @@
// Top level of the signed divide/remainder block: a pipelined restoring divider array.
// Depends on sdr_pkg, sdr_prep, sdr_cell and sdr_post.
//
//   port group   direction  payload    meaning
//   req_*        in         req_type   mode, dividend, divisor
//   rsp_*        out        rsp_type   quotient or remainder, zero-divisor flag
//
// One item enters per cycle while req_ready is high; each item passes through the
// input stage, one array cell per quotient bit and the output register.
// Every stage has its own valid bit and loads when empty or when its successor
// moves, so a stalled result fills the bubbles behind it before req_ready drops.
// Synchronous reset empties all stages; payload registers are not reset.
module signed_divide_remainder import sdr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   stage_type stage_data  [DATA_WIDTH+1];
   logic      stage_valid [DATA_WIDTH+1];
   logic      stage_ready [DATA_WIDTH+1];

   sdr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sdr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   sdr_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[DATA_WIDTH]),
      .in_ready  (stage_ready[DATA_WIDTH]),
      .in_data   (stage_data[DATA_WIDTH]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   a_accept_fills_prep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid[0])
      else $error("accepted item did not reach the input stage");

endmodule

@@ hw/rtl/sdr_prep.sv @@
// Input stage of the divider: signs, magnitudes and zero-divisor detection.
// Depends on sdr_pkg.
module sdr_prep import sdr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  req_type   in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   logic      load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      data_in.mode  = in_data.mode;
      data_in.neg_a = in_data.dividend[DATA_WIDTH-1];
      data_in.neg_b = in_data.divisor[DATA_WIDTH-1];
      data_in.dz    = (in_data.divisor == '0);
      // The magnitude of the most negative value is exact as an unsigned word.
      data_in.acc   = data_in.neg_a ? (DATA_WIDTH'(0) - DATA_WIDTH'(in_data.dividend))
                                    : DATA_WIDTH'(in_data.dividend);
      data_in.ub    = data_in.neg_b ? (DATA_WIDTH'(0) - DATA_WIDTH'(in_data.divisor))
                                    : DATA_WIDTH'(in_data.divisor);
      data_in.rem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/sdr_cell.sv @@
// One restoring shift-subtract step of the divider array, with its stage register.
// Depends on sdr_pkg.
module sdr_cell import sdr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic              valid_ff;
   stage_type         data_ff;
   stage_type         data_in;
   logic [DATA_WIDTH:0] shifted;
   logic [DATA_WIDTH:0] diff;
   logic              take;
   logic              load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // For a nonzero divisor the partial remainder stays below the divisor, so the
   // shifted value fits and the top bit of the difference is the borrow.
   assign shifted = {in_data.rem, in_data.acc[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, in_data.ub};
   assign take    = !diff[DATA_WIDTH];

   always_comb begin
      data_in     = in_data;
      data_in.rem = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      data_in.acc = {in_data.acc[DATA_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.dz |-> data_ff.rem < data_ff.ub)
      else $error("partial remainder not below divisor");

endmodule

@@ hw/rtl/sdr_post.sv @@
// Output stage of the divider: sign correction, mode select and the result register.
// Depends on sdr_pkg.
module sdr_post import sdr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output rsp_type   out_data
);

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;
   logic    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      data_in.divide_by_zero = in_data.dz;
      if (in_data.dz) begin
         data_in.result = '0;
      end else if (in_data.mode == MODE_REMAINDER) begin
         data_in.result = in_data.neg_a ? (DATA_WIDTH'(0) - in_data.rem) : in_data.rem;
      end else begin
         // The most negative dividend over minus one wraps back to itself.
         data_in.result = (in_data.neg_a ^ in_data.neg_b) ?
                          (DATA_WIDTH'(0) - in_data.acc) : in_data.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_zero_divisor_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.divide_by_zero |-> data_ff.result == '0)
      else $error("zero divisor must give a zero result");

   a_remainder_sign: assert property (@(posedge clock) disable iff (reset)
      load && in_data.mode == MODE_REMAINDER && !in_data.dz |=>
         data_ff.result == '0 || data_ff.result[DATA_WIDTH-1] == $past(in_data.neg_a))
      else $error("remainder sign differs from dividend sign");

endmodule
